[design/gha_pkg.sv]
// shared constants and types for the generational handle allocator
package gha_pkg;

  // default geometry
  localparam int INDEX_BITS_DEF = 12;
  localparam int GEN_BITS_DEF   = 20;
  localparam int SLOTS_DEF      = 4096;

  // operation codes carried on in_tuser
  typedef enum logic [1:0] {
    ACT_CREATE  = 2'd0,
    ACT_DESTROY = 2'd1,
    ACT_CHECK   = 2'd2
  } action_t;

endpackage

[design/gha_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/generational_handle_allocator.sv]
// generational handle allocator top level: control, counters and the two memories
//
// One item is in work at a time. Destroy, check and create from a fresh slot read
// the generation memory in the accept cycle and then update in S_EXEC, where the
// result register loads; create that reuses a freed slot passes through S_RING in
// between, since the slot index comes out of the free-ring memory before its
// generation can be read. Both memories have registered read data. The result sits
// in an output register, so a new item is taken while the previous result still
// waits; that next item then holds in its update cycle, with the input closed, until
// the waiting result is taken. No clearing pass runs after reset: slots at or above
// the fresh counter have never been handed out and read as generation 1, so the
// block is ready at once.
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int GEN_BITS   = GEN_BITS_DEF,
  parameter int SLOTS      = SLOTS_DEF,
  localparam int IN_DW  = ((INDEX_BITS + GEN_BITS + 7) / 8) * 8,
  localparam int CW     = INDEX_BITS + 1,
  localparam int OUT_DW = ((INDEX_BITS + GEN_BITS + CW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // slot_index, slot_generation, zero pad
  input  logic [1:0]        in_tuser,   // action
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // out_index, out_generation, live_count, zero pad
  output logic [0:0]        out_tuser   // ok
);

  localparam int AW = $clog2(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RING,
    S_EXEC
  } state_t;

  // generation increment that skips zero
  function automatic logic [GEN_BITS-1:0] bump_gen(input logic [GEN_BITS-1:0] g);
    logic [GEN_BITS-1:0] n;
    n = g + GEN_BITS'(1);
    return (n == '0) ? GEN_BITS'(2) : n;
  endfunction

  // ring pointer advance with wrap at the slot count
  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(SLOTS - 1)) ? '0 : p + AW'(1);
  endfunction

  state_t              state_r, state_nxt;
  action_t             act_r, act_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [GEN_BITS-1:0] gen_r, gen_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [CW-1:0]       freed_r, freed_nxt;
  logic [CW-1:0]       fresh_r, fresh_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]   out_data_r, out_data_nxt;
  logic                out_ok_r, out_ok_nxt;

  // memory ports
  logic                  gen_we, gen_re;
  logic [AW-1:0]         gen_waddr, gen_raddr;
  logic [GEN_BITS-1:0]   gen_wdata, gen_rdata;
  logic                  ring_we, ring_re;
  logic [AW-1:0]         ring_waddr;
  logic [INDEX_BITS-1:0] ring_wdata, ring_rdata;

  // execute-stage values
  logic [GEN_BITS-1:0]   gen_cur;
  logic                  in_range;
  logic                  handle_live;
  logic                  out_free;
  logic [INDEX_BITS-1:0] res_idx;
  logic [GEN_BITS-1:0]   res_gen;
  logic                  res_ok;

  gha_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOTS)) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .re    (gen_re),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  gha_ram #(.WIDTH(INDEX_BITS), .DEPTH(SLOTS)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (head_r),
    .rdata (ring_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;
  assign out_free   = !out_valid_r || out_tready;

  // slots never handed out still hold the reset generation
  assign gen_cur     = ({1'b0, idx_r} < fresh_r) ? gen_rdata : GEN_BITS'(1);
  assign in_range    = ({1'b0, idx_r} < CW'(SLOTS));
  assign handle_live = in_range && (gen_r != '0) && !gen_r[0] && (gen_cur == gen_r);

  // sequencer, counters and result formation
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    idx_nxt       = idx_r;
    gen_nxt       = gen_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    freed_nxt     = freed_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_ok_nxt    = out_ok_r;
    gen_re        = 1'b0;
    gen_raddr     = idx_r[AW-1:0];
    gen_we        = 1'b0;
    gen_waddr     = idx_r[AW-1:0];
    gen_wdata     = bump_gen(gen_cur);
    ring_re       = 1'b0;
    ring_we       = 1'b0;
    ring_waddr    = tail_r;
    ring_wdata    = idx_r;
    res_idx       = '0;
    res_gen       = '0;
    res_ok        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = action_t'(in_tuser);
          idx_nxt   = in_tdata[INDEX_BITS-1:0];
          gen_nxt   = in_tdata[INDEX_BITS+GEN_BITS-1:INDEX_BITS];
          gen_re    = 1'b1;
          gen_raddr = in_tdata[AW-1:0];
          ring_re   = 1'b1;
          if ((action_t'(in_tuser) == ACT_CREATE) && (freed_r != '0)) begin
            state_nxt = S_RING;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_RING: begin
        // read the generation of the slot taken from the ring
        gen_re    = 1'b1;
        gen_raddr = ring_rdata[AW-1:0];
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          case (act_r)
            ACT_CREATE: begin
              if (freed_r != '0) begin
                res_idx   = ring_rdata;
                res_gen   = bump_gen(gen_rdata);
                res_ok    = 1'b1;
                head_nxt  = ring_next(head_r);
                freed_nxt = freed_r - CW'(1);
              end else if (fresh_r < CW'(SLOTS)) begin
                res_idx   = fresh_r[INDEX_BITS-1:0];
                res_gen   = bump_gen(GEN_BITS'(1));
                res_ok    = 1'b1;
                fresh_nxt = fresh_r + CW'(1);
              end
              gen_we    = res_ok;
              gen_waddr = res_idx[AW-1:0];
              gen_wdata = res_gen;
            end
            ACT_DESTROY: begin
              if (handle_live) begin
                res_ok    = 1'b1;
                ring_we   = 1'b1;
                tail_nxt  = ring_next(tail_r);
                freed_nxt = freed_r + CW'(1);
                gen_we    = 1'b1;
              end
            end
            ACT_CHECK: begin
              res_ok = handle_live;
            end
            default: begin
              res_ok = 1'b0;
            end
          endcase
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok;
          out_data_nxt  = OUT_DW'({fresh_nxt - freed_nxt, res_gen, res_idx});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, counters and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      freed_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      freed_r     <= freed_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r      <= act_nxt;
    idx_r      <= idx_nxt;
    gen_r      <= gen_nxt;
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
  end

endmodule

[design/gha_chk.sv]
// port-level checker for the generational handle allocator and its bind
module gha_chk
  import gha_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int GEN_BITS   = GEN_BITS_DEF,
  parameter int SLOTS      = SLOTS_DEF,
  localparam int CW     = INDEX_BITS + 1,
  localparam int OUT_DW = ((INDEX_BITS + GEN_BITS + CW + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic [0:0]        out_tuser
);

  logic [INDEX_BITS-1:0] o_idx;
  logic [GEN_BITS-1:0]   o_gen;
  logic [CW-1:0]         o_live;

  assign o_idx  = out_tdata[INDEX_BITS-1:0];
  assign o_gen  = out_tdata[INDEX_BITS+GEN_BITS-1:INDEX_BITS];
  assign o_live = out_tdata[INDEX_BITS+GEN_BITS+CW-1:INDEX_BITS+GEN_BITS];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in work");

  // a failed or non-create result carries a zero handle
  a_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (o_idx == '0) && (o_gen == '0))
    else $error("nonzero handle without ok");

  // a handed-out generation is even, i.e. alive
  a_even_gen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (o_gen != '0) |-> !o_gen[0] && out_tuser[0] && (o_idx < SLOTS))
    else $error("new handle has a dead generation or bad index");

  // live count never exceeds the slot count
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_live <= CW'(SLOTS)))
    else $error("live count beyond slot count");

endmodule

bind generational_handle_allocator gha_chk #(
  .INDEX_BITS (INDEX_BITS),
  .GEN_BITS   (GEN_BITS),
  .SLOTS      (SLOTS)
) u_gha_chk (.*);

[dv/generational_handle_allocator_test.sv]
// testbench for the generational handle allocator: handle scoreboard, stream drivers and checks
module generational_handle_allocator_test
  import gha_pkg::*;
;

  localparam int IDX_W  = INDEX_BITS_DEF;
  localparam int GEN_W  = GEN_BITS_DEF;
  localparam int SLOTS  = SLOTS_DEF;
  localparam int CNT_W  = IDX_W + 1;
  localparam int IN_DW  = ((IDX_W + GEN_W + 7) / 8) * 8;
  localparam int OUT_DW = ((IDX_W + GEN_W + CNT_W + 7) / 8) * 8;

  // code outside the defined operations, which the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 980;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    logic             ok;
    logic [CNT_W-1:0] live;
  } reply_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } handle_t;

  // predicts every reply from its own copy of the slot table and free ring
  class handle_scoreboard;
    logic [GEN_W-1:0] gen_tbl [SLOTS];
    logic [IDX_W-1:0] free_ring [SLOTS];
    int ring_head;
    int ring_tail;
    int freed_count;
    int fresh_next;
    int errors;
    reply_t expected_replies[$];

    function new();
      foreach (gen_tbl[i]) gen_tbl[i] = 1;
      ring_head   = 0;
      ring_tail   = 0;
      freed_count = 0;
      fresh_next  = 0;
      errors      = 0;
    endfunction

    // odd to even and back; a wrap to zero skips ahead to 2
    function logic [GEN_W-1:0] next_gen(logic [GEN_W-1:0] g);
      logic [GEN_W-1:0] n;
      n = g + 1'b1;
      return (n == '0) ? GEN_W'(2) : n;
    endfunction

    // apply one accepted request and queue the reply it must produce
    function reply_t note_request(logic [1:0] act, logic [IDX_W-1:0] idx,
                                  logic [GEN_W-1:0] gen);
      reply_t r;
      logic [IDX_W-1:0] slot;
      bit got;
      bit handle_live;
      r = '0;
      got = 0;
      slot = '0;
      handle_live = (int'(idx) < SLOTS) && gen != '0 && !gen[0] && gen_tbl[idx] == gen;
      case (act)
        ACT_CREATE: begin
          // oldest freed slot first, else the next fresh one
          if (freed_count != 0) begin
            slot = free_ring[ring_head];
            ring_head = (ring_head + 1) % SLOTS;
            freed_count--;
            got = 1;
          end else if (fresh_next < SLOTS) begin
            slot = IDX_W'(fresh_next);
            fresh_next++;
            got = 1;
          end
          if (got) begin
            gen_tbl[slot] = next_gen(gen_tbl[slot]);
            r.idx = slot;
            r.gen = gen_tbl[slot];
            r.ok  = 1'b1;
          end
        end
        ACT_DESTROY: begin
          if (handle_live) begin
            free_ring[ring_tail] = idx;
            ring_tail = (ring_tail + 1) % SLOTS;
            freed_count++;
            gen_tbl[idx] = next_gen(gen_tbl[idx]);
            r.ok = 1'b1;
          end
        end
        ACT_CHECK: r.ok = handle_live;
        default: ;
      endcase
      r.live = CNT_W'(fresh_next - freed_count);
      expected_replies.push_back(r);
      return r;
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // compare one accepted result with the oldest pending reply
    task check_reply(logic [OUT_DW-1:0] data, logic ok);
      reply_t want;
      logic [IDX_W-1:0] got_idx;
      logic [GEN_W-1:0] got_gen;
      logic [CNT_W-1:0] got_live;
      got_idx  = data[IDX_W-1:0];
      got_gen  = data[IDX_W+GEN_W-1:IDX_W];
      got_live = data[IDX_W+GEN_W+CNT_W-1:IDX_W+GEN_W];
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("result with no request pending (index %0d gen %0d)",
                                  got_idx, got_gen));
        return;
      end
      want = expected_replies.pop_front();
      if (got_idx !== want.idx)
        report_mismatch($sformatf("index %0h, want %0h", got_idx, want.idx));
      if (got_gen !== want.gen)
        report_mismatch($sformatf("generation %0h, want %0h", got_gen, want.gen));
      if (ok !== want.ok)
        report_mismatch($sformatf("ok %b, want %b", ok, want.ok));
      if (got_live !== want.live)
        report_mismatch($sformatf("live count %0d, want %0d", got_live, want.live));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;   // slot_index, slot_generation, zero pad
  logic [1:0]        in_tuser;   // action
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;  // out_index, out_generation, live_count, zero pad
  logic [0:0]        out_tuser;  // ok

  handle_scoreboard sb = new();
  handle_t live_handles[$];
  handle_t retired_handles[$];
  reply_t  last_reply;
  bit      steady;
  bit      hold_req;
  int      stall_cycles;

  generational_handle_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // offer one item from a falling edge and hold it until the block takes it
  task automatic send_item(logic [1:0] act, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    logic [IN_DW-1:0] word;
    int pos[$];
    handle_t h;
    word = '0;
    word[IDX_W-1:0] = idx;
    word[IDX_W+GEN_W-1:IDX_W] = gen;
    while (!steady && $urandom_range(0, 99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    last_reply = sb.note_request(act, idx, gen);
    // keep the handle lists in step with the table
    if (act == ACT_CREATE && last_reply.ok) begin
      h.idx = last_reply.idx;
      h.gen = last_reply.gen;
      live_handles.push_back(h);
    end else if (act == ACT_DESTROY && last_reply.ok) begin
      pos = live_handles.find_first_index(x) with (x.idx == idx && x.gen == gen);
      if (pos.size() != 0) live_handles.delete(pos[0]);
      h.idx = idx;
      h.gen = gen;
      retired_handles.push_back(h);
      if (retired_handles.size() > 64) void'(retired_handles.pop_front());
    end
    @(negedge clk);
  endtask

  // reset state, rejected handles, first reuse and the top of both fields
  task automatic directed_items();
    send_item(ACT_CHECK, 0, 1);
    send_item(ACT_DESTROY, 0, 1);
    send_item(ACT_CREATE, 0, 0);
    send_item(ACT_CHECK, 0, 2);
    send_item(ACT_CHECK, 0, 0);
    send_item(ACT_DESTROY, 0, 4);
    send_item(ACT_DESTROY, 0, 0);
    send_item(ACT_CREATE, '1, '1);
    send_item(ACT_DESTROY, 0, 2);
    send_item(ACT_CHECK, 0, 2);
    send_item(ACT_DESTROY, 0, 2);
    send_item(ACT_CHECK, 1, 2);
    send_item(ACT_CREATE, 0, 0);
    send_item(ACT_UNUSED, '1, '1);
    send_item(ACT_UNUSED, 0, 0);
    send_item(ACT_CHECK, '1, '1 - 1'b1);
    send_item(ACT_DESTROY, '1, '1);
    send_item(ACT_CHECK, '1, '1);
    send_item(ACT_DESTROY, 1, 2);
    send_item(ACT_DESTROY, 0, 4);
    send_item(ACT_CREATE, 0, 0);
    send_item(ACT_CREATE, 0, 0);
    send_item(ACT_CREATE, '1, '1);
  endtask

  // mostly real handles, some stale or corrupted ones and some noise
  task automatic random_item();
    int pick;
    handle_t h;
    logic [GEN_W-1:0] g;
    logic [1:0] act;
    pick = $urandom_range(0, 99);
    if (live_handles.size() > 150 && pick < 34) pick = 40;
    if (live_handles.size() == 0 && (pick >= 34 && pick < 74 || pick >= 82 && pick < 88))
      pick = 0;
    if (retired_handles.size() == 0 && pick >= 74 && pick < 82) pick = 0;
    if (pick < 34) begin
      send_item(ACT_CREATE, IDX_W'($urandom), GEN_W'($urandom));
    end else if (pick < 74) begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      act = (pick < 58) ? ACT_DESTROY : ACT_CHECK;
      send_item(act, h.idx, h.gen);
    end else if (pick < 82) begin
      h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
      act = $urandom_range(0, 1) ? ACT_DESTROY : ACT_CHECK;
      send_item(act, h.idx, h.gen);
    end else if (pick < 88) begin
      // a live handle with one generation bit flipped, or a zero generation
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      g = ($urandom_range(0, 3) == 0) ? '0 : h.gen ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1));
      act = $urandom_range(0, 1) ? ACT_DESTROY : ACT_CHECK;
      send_item(act, h.idx, g);
    end else if (pick < 96) begin
      g = $urandom_range(0, 1) ? GEN_W'($urandom) : GEN_W'($urandom_range(0, 3) * 2);
      act = $urandom_range(0, 1) ? ACT_DESTROY : ACT_CHECK;
      send_item(act, IDX_W'($urandom), g);
    end else begin
      send_item(ACT_UNUSED, IDX_W'($urandom), GEN_W'($urandom));
    end
  endtask

  // result side: ready decided at the rising edge, applied at the falling one
  initial begin
    bit rdy_next;
    int hold_left;
    rdy_next   = 1'b1;
    hold_left  = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      out_tready <= rdy_next;
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_reply(out_tdata, out_tuser[0]);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy_next = 1'b0;
      end else begin
        rdy_next = steady || $urandom_range(0, 99) >= 22;
      end
    end
  end

  // give up after a long run of cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("generational_handle_allocator_test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    handle_t h;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_CREATE;
    steady    = 1'b0;
    hold_req  = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_items();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 500) hold_req = 1'b1;
      steady = (n >= 700 && n < 850);
      random_item();
    end

    // free every live slot in random order
    live_handles.shuffle();
    while (live_handles.size() != 0) begin
      h = live_handles.pop_front();
      send_item(ACT_DESTROY, h.idx, h.gen);
      if ($urandom_range(0, 7) == 0) send_item(ACT_CHECK, h.idx, h.gen);
    end
    in_tvalid <= 1'b0;

    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("generational_handle_allocator_test passed");
    end else begin
      $display("generational_handle_allocator_test failed");
    end
    $finish;
  end

endmodule

[generational_handle_allocator.f]
design/gha_pkg.sv
design/gha_ram.sv
design/generational_handle_allocator.sv
design/gha_chk.sv
dv/generational_handle_allocator_test.sv
